/* design/mss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the maximum subcube sum engine.
// ----------------------------------------------------------------------------
package mss_pkg;

    // default cube edge limit
    localparam int DEF_MAX_EDGE = 16;

    // field widths
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 27;
    localparam int CFG_W   = 5;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ZERO,
        ST_SUMJ,
        ST_SUMJ_WAIT,
        ST_SUMK,
        ST_SUMK_WAIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_EMIT
    } state_t;

    // four corner terms of one per-row box sum
    typedef enum logic [1:0] {
        TERM_TH,    // depth t, column h
        TERM_RH,    // depth r-1, column h
        TERM_TG,    // depth t, column g-1
        TERM_RG     // depth r-1, column g-1
    } term_t;

    // tag that travels with a RAM read
    typedef struct packed {
        logic  valid;
        logic  prefix;   // running-sum pass (else box scan)
        logic  first;    // first element of a run
        term_t term;
        logic  incl;     // term takes part in the box sum
    } rd_tag_t;

    localparam rd_tag_t TAG_IDLE = '{
        valid:  1'b0,
        prefix: 1'b0,
        first:  1'b0,
        term:   TERM_TH,
        incl:   1'b0
    };

endpackage

/* design/mss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/max_subcube_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subcube_sum
// Loads an N x N x N cube of signed values, builds running sums along j and
// k in place, then scans every column and depth range with Kadane's method
// over the rows and returns the largest subcube sum (zero if all negative).
// ----------------------------------------------------------------------------
// Load: one beat per cycle while ready is high; ready is held low after a cube_size
// write until the settle counter clears. After the last beat: zero-fill of unwritten
// positions, a running-sum pass along j and one along k, the box scan (four corner
// reads per row on the single read port), then emit, which waits while a result is unread.
// The block takes no beat from the last beat until the result is registered.
// Sync active-low reset clears control state and sets cube_size to MAX_EDGE.
// ----------------------------------------------------------------------------
module max_subcube_sum #(
    parameter int MAX_EDGE = mss_pkg::DEF_MAX_EDGE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mss_pkg::VALUE_W-1:0] s_value,
    input  logic                              s_last,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mss_pkg::SUM_W-1:0]         m_best_sum,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mss_pkg::CFG_W-1:0]         cfg_wr_data
);

    import mss_pkg::*;

    localparam int DEPTH   = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int EW      = $clog2(MAX_EDGE + 1);
    localparam int LOG_E   = $clog2(MAX_EDGE);
    localparam int CELL_W  = VALUE_W + 2 * LOG_E + 1;
    localparam int BOX_W   = CELL_W + 2;
    localparam int RUN_RAW = VALUE_W + 3 * LOG_E + 1;
    localparam int RUN_W   = (RUN_RAW > SUM_W) ? RUN_RAW : SUM_W + 1;
    localparam int CLAMP_W = 8;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         load_idx_reg, load_idx_next;
    logic [EW-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]         sq_reg, total_reg;
    logic [1:0]               settle_reg, settle_next;
    logic [CNT_W-1:0]         addr_reg, addr_next;
    logic [CNT_W-1:0]         p_reg, p_next;
    logic [EW-1:0]            j_reg, j_next;
    logic [EW-1:0]            g_reg, g_next;
    logic [EW-1:0]            gm_reg, gm_next;
    logic [EW-1:0]            h_reg, h_next;
    logic [EW-1:0]            r_reg, r_next;
    logic [EW-1:0]            t_reg, t_next;
    logic [EW-1:0]            i_reg, i_next;
    term_t                    term_reg, term_next;
    logic [CNT_W-1:0]         t_base_reg, t_base_next;
    logic [CNT_W-1:0]         r_base_reg, r_base_next;
    logic [CNT_W-1:0]         rm_base_reg, rm_base_next;
    logic [CNT_W-1:0]         row_base_reg, row_base_next;
    rd_tag_t                  tag_reg, tag_next;
    logic [CNT_W-1:0]         wb_addr_reg, wb_addr_next;
    logic signed [CELL_W-1:0] acc_reg, acc_next;
    logic signed [BOX_W-1:0]  box_reg, box_next;
    logic                     box_vld_reg, box_vld_next;
    logic                     box_first_reg, box_first_next;
    logic signed [RUN_W-1:0]  run_reg, run_next;
    logic                     run_vld_reg, run_vld_next;
    logic signed [RUN_W-1:0]  best_reg, best_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]         m_sum_reg, m_sum_next;

    // RAM port signals
    logic                     ram_we;
    logic [CNT_W-1:0]         ram_waddr;
    logic signed [CELL_W-1:0] ram_wdata;
    logic [CNT_W-1:0]         ram_raddr;
    logic signed [CELL_W-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // cube store
    // ------------------------------------------------------------------
    mss_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer, address generation and datapath
    // ------------------------------------------------------------------
    always_comb begin
        logic [CLAMP_W-1:0]       cfg_wide;
        logic [EW-1:0]            nm1;
        logic signed [CELL_W-1:0] cell_sum;
        logic signed [BOX_W-1:0]  term_val;
        logic signed [RUN_W-1:0]  run_base;
        logic signed [RUN_W-1:0]  run_sum;
        logic [CNT_W-1:0]         scan_base;
        logic [EW-1:0]            scan_col;
        logic                     scan_incl;

        cfg_wide  = {{(CLAMP_W - CFG_W){1'b0}}, cfg_wr_data};
        nm1       = n_reg - 1'b1;
        cell_sum  = '0;
        term_val  = '0;
        run_base  = '0;
        run_sum   = '0;
        scan_base = '0;
        scan_col  = '0;
        scan_incl = 1'b0;

        state_next     = state_reg;
        load_idx_next  = load_idx_reg;
        n_next         = n_reg;
        settle_next    = (settle_reg != 2'd0) ? settle_reg - 2'd1 : 2'd0;
        addr_next      = addr_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        g_next         = g_reg;
        gm_next        = gm_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        i_next         = i_reg;
        term_next      = term_reg;
        t_base_next    = t_base_reg;
        r_base_next    = r_base_reg;
        rm_base_next   = rm_base_reg;
        row_base_next  = row_base_reg;
        tag_next       = TAG_IDLE;
        wb_addr_next   = wb_addr_reg;
        acc_next       = acc_reg;
        box_next       = box_reg;
        box_vld_next   = 1'b0;
        box_first_next = box_first_reg;
        run_next       = run_reg;
        run_vld_next   = box_vld_reg;
        best_next      = best_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sum_next     = m_sum_reg;

        ram_we    = 1'b0;
        ram_waddr = load_idx_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;

        s_ready = (state_reg == ST_LOAD) && (settle_reg == 2'd0);

        // cube_size write, clamped to 1..MAX_EDGE
        if (cfg_wr_en) begin
            settle_next = 2'd2;
            if (cfg_wide == '0) begin
                n_next = EW'(1);
            end else if (cfg_wide > CLAMP_W'(MAX_EDGE)) begin
                n_next = EW'(MAX_EDGE);
            end else begin
                n_next = EW'(cfg_wide);
            end
        end

        // read data stage: running-sum write-back
        if (tag_reg.valid && tag_reg.prefix) begin
            cell_sum  = tag_reg.first ? ram_rdata : acc_reg + ram_rdata;
            acc_next  = cell_sum;
            ram_we    = 1'b1;
            ram_waddr = wb_addr_reg;
            ram_wdata = cell_sum;
        end

        // read data stage: box sum by inclusion and exclusion
        if (tag_reg.valid && !tag_reg.prefix) begin
            term_val = {{2{ram_rdata[CELL_W-1]}}, ram_rdata};
            unique case (tag_reg.term)
                TERM_TH: box_next = term_val;
                TERM_RH,
                TERM_TG: box_next = tag_reg.incl ? box_reg - term_val : box_reg;
                TERM_RG: box_next = tag_reg.incl ? box_reg + term_val : box_reg;
                default: box_next = box_reg;
            endcase
            box_vld_next   = (tag_reg.term == TERM_RG);
            box_first_next = tag_reg.first;
        end

        // Kadane step, running sum clamped at zero
        if (box_vld_reg) begin
            run_base = box_first_reg ? '0 : run_reg;
            run_sum  = run_base + {{(RUN_W - BOX_W){box_reg[BOX_W-1]}}, box_reg};
            run_next = run_sum[RUN_W-1] ? '0 : run_sum;
        end

        // best tracking
        if (run_vld_reg && (run_reg > best_reg)) begin
            best_next = run_reg;
        end

        unique case (state_reg)
            // store beats at linear positions
            ST_LOAD: begin
                if (s_valid && s_ready) begin
                    if (load_idx_reg < total_reg) begin
                        ram_we        = 1'b1;
                        ram_waddr     = load_idx_reg;
                        ram_wdata     = {{(CELL_W - VALUE_W){s_value[VALUE_W-1]}}, s_value};
                        load_idx_next = load_idx_reg + 1'b1;
                    end
                    if (s_last) begin
                        state_next = ST_ZERO;
                        addr_next  = load_idx_next;
                    end
                end
            end

            // clear the positions a short cube left unwritten
            ST_ZERO: begin
                if (addr_reg < total_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg;
                    ram_wdata = '0;
                    addr_next = addr_reg + 1'b1;
                end else begin
                    state_next = ST_SUMJ;
                    addr_next  = '0;
                    j_next     = '0;
                end
            end

            // running sums along j, linear walk
            ST_SUMJ: begin
                ram_raddr    = addr_reg;
                tag_next     = '{valid: 1'b1, prefix: 1'b1, first: (j_reg == '0),
                                 term: TERM_TH, incl: 1'b0};
                wb_addr_next = addr_reg;
                addr_next    = addr_reg + 1'b1;
                j_next       = (j_reg == nm1) ? '0 : j_reg + 1'b1;
                if (addr_reg == total_reg - 1'b1) begin
                    state_next = ST_SUMJ_WAIT;
                end
            end

            ST_SUMJ_WAIT: begin
                if (!tag_reg.valid) begin
                    state_next = ST_SUMK;
                    addr_next  = '0;
                    p_next     = '0;
                    j_next     = '0;
                end
            end

            // running sums along k, stride N*N per step
            ST_SUMK: begin
                ram_raddr    = addr_reg;
                tag_next     = '{valid: 1'b1, prefix: 1'b1, first: (j_reg == '0),
                                 term: TERM_TH, incl: 1'b0};
                wb_addr_next = addr_reg;
                if (j_reg == nm1) begin
                    j_next    = '0;
                    p_next    = p_reg + 1'b1;
                    addr_next = p_reg + 1'b1;
                    if (p_reg == sq_reg - 1'b1) begin
                        state_next = ST_SUMK_WAIT;
                    end
                end else begin
                    j_next    = j_reg + 1'b1;
                    addr_next = addr_reg + sq_reg;
                end
            end

            ST_SUMK_WAIT: begin
                if (!tag_reg.valid) begin
                    state_next    = ST_SCAN;
                    g_next        = '0;
                    gm_next       = '0;
                    h_next        = '0;
                    r_next        = '0;
                    t_next        = '0;
                    i_next        = '0;
                    term_next     = TERM_TH;
                    t_base_next   = '0;
                    r_base_next   = '0;
                    rm_base_next  = '0;
                    row_base_next = '0;
                    best_next     = '0;
                end
            end

            // box scan: four corner reads per row, loops g, h, r, t, i
            ST_SCAN: begin
                scan_base = ((term_reg == TERM_TH) || (term_reg == TERM_TG))
                          ? t_base_reg : rm_base_reg;
                scan_col  = ((term_reg == TERM_TH) || (term_reg == TERM_RH))
                          ? h_reg : gm_reg;
                unique case (term_reg)
                    TERM_TH: scan_incl = 1'b1;
                    TERM_RH: scan_incl = (r_reg != '0);
                    TERM_TG: scan_incl = (g_reg != '0);
                    TERM_RG: scan_incl = (r_reg != '0) && (g_reg != '0);
                    default: scan_incl = 1'b0;
                endcase
                ram_raddr = scan_base + row_base_reg + CNT_W'(scan_col);
                tag_next  = '{valid: 1'b1, prefix: 1'b0, first: (i_reg == '0),
                              term: term_reg, incl: scan_incl};

                unique case (term_reg)
                    TERM_TH: term_next = TERM_RH;
                    TERM_RH: term_next = TERM_TG;
                    TERM_TG: term_next = TERM_RG;
                    TERM_RG: term_next = TERM_TH;
                    default: term_next = TERM_TH;
                endcase

                if (term_reg == TERM_RG) begin
                    if (i_reg != nm1) begin
                        i_next        = i_reg + 1'b1;
                        row_base_next = row_base_reg + CNT_W'(n_reg);
                    end else begin
                        i_next        = '0;
                        row_base_next = '0;
                        if (t_reg != nm1) begin
                            t_next      = t_reg + 1'b1;
                            t_base_next = t_base_reg + sq_reg;
                        end else if (r_reg != nm1) begin
                            r_next       = r_reg + 1'b1;
                            rm_base_next = r_base_reg;
                            r_base_next  = r_base_reg + sq_reg;
                            t_next       = r_reg + 1'b1;
                            t_base_next  = r_base_reg + sq_reg;
                        end else begin
                            r_next       = '0;
                            r_base_next  = '0;
                            rm_base_next = '0;
                            t_next       = '0;
                            t_base_next  = '0;
                            if (h_reg != nm1) begin
                                h_next = h_reg + 1'b1;
                            end else if (g_reg != nm1) begin
                                g_next  = g_reg + 1'b1;
                                gm_next = g_reg;
                                h_next  = g_reg + 1'b1;
                            end else begin
                                state_next = ST_SCAN_WAIT;
                            end
                        end
                    end
                end
            end

            // drain the read, box and Kadane stages
            ST_SCAN_WAIT: begin
                if (!tag_reg.valid && !box_vld_reg && !run_vld_reg) begin
                    state_next = ST_EMIT;
                end
            end

            // hand the result to the output register
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sum_next    = best_reg[SUM_W-1:0];
                    load_idx_next = '0;
                    state_next    = ST_LOAD;
                end
            end

            default: state_next = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // state register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg <= '0;
            n_reg        <= EW'(MAX_EDGE);
            sq_reg       <= CNT_W'(MAX_EDGE * MAX_EDGE);
            total_reg    <= CNT_W'(DEPTH);
            settle_reg   <= 2'd0;
            tag_reg      <= TAG_IDLE;
            box_vld_reg  <= 1'b0;
            run_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            load_idx_reg <= load_idx_next;
            n_reg        <= n_next;
            // N*N is registered from the edge register, and N^3 from N*N
            sq_reg       <= CNT_W'(n_reg) * CNT_W'(n_reg);
            total_reg    <= sq_reg * CNT_W'(n_reg);
            settle_reg   <= settle_next;
            tag_reg      <= tag_next;
            box_vld_reg  <= box_vld_next;
            run_vld_reg  <= run_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        p_reg         <= p_next;
        j_reg         <= j_next;
        g_reg         <= g_next;
        gm_reg        <= gm_next;
        h_reg         <= h_next;
        r_reg         <= r_next;
        t_reg         <= t_next;
        i_reg         <= i_next;
        term_reg      <= term_next;
        t_base_reg    <= t_base_next;
        r_base_reg    <= r_base_next;
        rm_base_reg   <= rm_base_next;
        row_base_reg  <= row_base_next;
        wb_addr_reg   <= wb_addr_next;
        acc_reg       <= acc_next;
        box_reg       <= box_next;
        box_first_reg <= box_first_next;
        run_reg       <= run_next;
        best_reg      <= best_next;
        m_sum_reg     <= m_sum_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_best_sum = m_sum_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_subcube_sum. Cube elements are streamed on the
// input channel; an in-bench model of the 3D Kadane search predicts the best
// subcube sum for every beat marked last, and each result beat is compared
// with the oldest prediction. Covers edge clamping, short and overlong cubes,
// a resize in the middle of a load, a long result stall and random traffic.
// ----------------------------------------------------------------------------
module testbench;
    import mss_pkg::*;

    localparam int MAX_EDGE    = DEF_MAX_EDGE;
    localparam int STORE_DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int LONG_HOLD   = 3000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic signed [VALUE_W-1:0]   s_value     = '0;
    logic                        s_last      = 1'b0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [SUM_W-1:0]            m_best_sum;
    logic                        cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]            cfg_wr_data = '0;

    // traffic shaping
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_req          = 1'b0;

    // cube model state
    int               cube_img [0:STORE_DEPTH-1];
    int               fill_count = 0;
    logic [CFG_W-1:0] size_reg   = CFG_W'(MAX_EDGE);

    logic [SUM_W-1:0] pending_best_sums [$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;

    max_subcube_sum dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_best_sum  (m_best_sum),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // 0 acts as 1, anything above the store limit acts as the limit
    function automatic int active_edge();
        if (size_reg == 0) return 1;
        if (int'(size_reg) > MAX_EDGE) return MAX_EDGE;
        return int'(size_reg);
    endfunction

    function automatic int cell_at(int n, int k, int i, int j);
        return (k * n + i) * n + j;
    endfunction

    // prefix sums in place, then Kadane over rows for every column/depth range
    function automatic logic [SUM_W-1:0] best_subcube(int n);
        int total;
        int best;
        int run;
        int box;
        total = n * n * n;
        for (int a = fill_count; a < total; a++) cube_img[a] = 0;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 1; j < n; j++)
                    cube_img[cell_at(n, k, i, j)] += cube_img[cell_at(n, k, i, j - 1)];
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                for (int k = 1; k < n; k++)
                    cube_img[cell_at(n, k, i, j)] += cube_img[cell_at(n, k - 1, i, j)];
        best = 0;
        for (int g = 0; g < n; g++)
            for (int h = g; h < n; h++)
                for (int r = 0; r < n; r++)
                    for (int t = r; t < n; t++) begin
                        run = 0;
                        for (int i = 0; i < n; i++) begin
                            box = cube_img[cell_at(n, t, i, h)];
                            if (r > 0) box -= cube_img[cell_at(n, r - 1, i, h)];
                            if (g > 0) box -= cube_img[cell_at(n, t, i, g - 1)];
                            if (r > 0 && g > 0) box += cube_img[cell_at(n, r - 1, i, g - 1)];
                            run += box;
                            if (run < 0) run = 0;
                            if (run > best) best = run;
                        end
                    end
        return best[SUM_W-1:0];
    endfunction

    // one accepted element; extras beyond N^3 are dropped, last always searches
    task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input logic l);
        int total;
        total = active_edge() ** 3;
        if (fill_count < total) begin
            cube_img[fill_count] = int'(v);
            fill_count++;
        end
        if (l) begin
            pending_best_sums.push_back(best_subcube(active_edge()));
            fill_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic l);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        do @(posedge aclk); while (s_ready !== 1'b1);
        absorb_element(v, l);
    endtask

    // drop valid, then wait until every predicted result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_best_sums.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cube_size(input logic [CFG_W-1:0] size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        size_reg = size;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        int pick;
        int s;
        pick = $urandom_range(0, 3);
        if (pick == 0) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        s = int'($urandom_range(0, 200)) - 100;
        if (pick == 1) return s[VALUE_W-1:0];
        s = int'($urandom);
        return s[VALUE_W-1:0];
    endfunction

    // mostly complete cubes, some short, some with extra elements
    task automatic send_cube(output int sent);
        int total;
        int count;
        total = active_edge() ** 3;
        case ($urandom_range(0, 9))
            0, 1: begin
                count = $urandom_range(1, total);
            end
            2: begin
                count = total + $urandom_range(1, 4);
            end
            default: begin
                count = total;
            end
        endcase
        for (int e = 1; e <= count; e++) send_beat(random_value(), e == count);
        sent = count;
    endtask

    // small edges dominate; the search cost grows with N^5
    function automatic logic [CFG_W-1:0] random_cube_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return CFG_W'(0);
        if (pick <= 4) return CFG_W'(1);
        if (pick <= 10) return CFG_W'(2);
        if (pick <= 16) return CFG_W'(3);
        if (pick <= 18) return CFG_W'(4);
        return CFG_W'(5);
    endfunction

    // result ready: random stalls, plus one long hold on request
    initial begin : result_ready_driver
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    always @(posedge aclk) begin
        logic [SUM_W-1:0] want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_best_sums.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing expected, got %0d",
                                        m_best_sum));
            end else begin
                want = pending_best_sums.pop_front();
                if (m_best_sum !== want)
                    flag_mismatch($sformatf("best_sum expected %0d, got %0d",
                                            want, m_best_sum));
            end
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // edge left at its reset value (full size), short cube with extreme values
    task automatic test_reset_edge();
        send_beat(VAL_MAX, 1'b0);
        send_beat(VAL_MIN, 1'b0);
        send_beat(VAL_MAX, 1'b0);
        send_beat(16'sd1, 1'b1);
        drain_results();
    endtask

    // size 0 acts as 1: all-negative cube, then extras and last past a full cube
    task automatic test_edge_zero();
        write_cube_size(CFG_W'(0));
        send_beat(-16'sd5, 1'b1);
        send_beat(16'sd7, 1'b0);
        send_beat(16'sd3, 1'b0);
        send_beat(-16'sd2, 1'b1);
        drain_results();
    endtask

    // size 31 clamps to the limit; shrink mid-load so stored count exceeds N^3
    task automatic test_clamp_and_resize();
        write_cube_size(CFG_W'(31));
        for (int e = 0; e < 10; e++) send_beat(random_value(), 1'b0);
        drain_results();
        write_cube_size(CFG_W'(2));
        send_beat(VAL_MIN, 1'b1);
        drain_results();
    endtask

    // every element at the positive limit
    task automatic test_saturated_cube();
        write_cube_size(CFG_W'(2));
        for (int e = 1; e <= 8; e++) send_beat(VAL_MAX, e == 8);
        drain_results();
    endtask

    // long result stall while cubes keep coming, so the input backs up
    task automatic test_result_backpressure();
        int sent;
        write_cube_size(CFG_W'(2));
        hold_req = 1'b1;
        repeat (3) send_cube(sent);
        drain_results();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int item_goal, input int result_goal);
        int items;
        int results;
        int sent;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        items   = 0;
        results = 0;
        while (items < item_goal || results < result_goal) begin
            if (results == 0 || $urandom_range(0, 2) == 0) begin
                drain_results();
                write_cube_size(random_cube_size());
            end
            send_cube(sent);
            items += sent;
            results++;
        end
        drain_results();
    endtask

    initial begin : main
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 35;
        receiver_idle_pct = 71;
        test_reset_edge();
        test_edge_zero();
        test_clamp_and_resize();
        test_saturated_cube();
        test_result_backpressure();

        test_random_traffic(35, 71, 170, 6);
        test_random_traffic(71, 35, 170, 6);
        test_random_traffic(0, 0, 170, 6);

        repeat (20) @(posedge aclk);
        if (pending_best_sums.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_best_sums.size()));
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
